/* rtl/core/miv_pkg.sv */
// ----------------------------------------------------------------------------
// miv_pkg
// Shared types and constants for the extended Euclid modular inverse block.
// ----------------------------------------------------------------------------
`default_nettype none

package miv_pkg;

  localparam int unsigned FIELD_W = 63;

  typedef struct packed {
    logic [FIELD_W-1:0] value;
    logic [FIELD_W-1:0] modulus;
  } miv_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] inverse;
    logic [FIELD_W-1:0] common_divisor;
    logic               invertible;
  } miv_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_STEP,
    ST_REDUCE
  } miv_state_e;

endpackage

`default_nettype wire

/* rtl/core/miv_divider.sv */
// ----------------------------------------------------------------------------
// miv_divider
// Iterative restoring divider, one quotient bit per cycle, that also builds
// the product of the quotient and a multiplicand by shift and add.
// ----------------------------------------------------------------------------
`default_nettype none

module miv_divider #(
  parameter int unsigned W  = 63,
  parameter int unsigned CW = W + 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [W-1:0]  dividend_i,
  input  wire logic [W-1:0]  divisor_i,
  input  wire logic [CW-1:0] mult_i,
  output logic               done_o,
  output logic [W-1:0]       rem_o,
  output logic [CW-1:0]      prod_o
);

  localparam int unsigned CNT_W = $clog2(W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [W-1:0]     rem_q, rem_d;
  logic [W-1:0]     dvd_q, dvd_d;
  logic [W-1:0]     den_q, den_d;
  logic [CW-1:0]    mult_q, mult_d;
  logic [CW-1:0]    prod_q, prod_d;

  logic [W:0] trial;
  logic [W:0] diff;
  logic       ge;

  assign trial = {rem_q, dvd_q[W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    den_d  = den_q;
    mult_d = mult_q;
    prod_d = prod_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(W);
      rem_d  = '0;
      dvd_d  = dividend_i;
      den_d  = divisor_i;
      mult_d = mult_i;
      prod_d = '0;
    end else if (busy_q) begin
      // quotient bits arrive msb first, so the product is built horner style
      rem_d  = ge ? diff[W-1:0] : trial[W-1:0];
      dvd_d  = dvd_q << 1;
      prod_d = (prod_q << 1) + (ge ? mult_q : '0);
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvd_q  <= dvd_d;
    den_q  <= den_d;
    mult_q <= mult_d;
    prod_q <= prod_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;
  assign prod_o = prod_q;

  // remainder left by a finished division is below the divisor
  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rem_q < den_q)
    else $error("divider remainder not below divisor");

  // done follows the last bit step only
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a running division");

  // the counter never runs out while busy
  a_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0)
    else $error("divider bit counter empty while busy");

endmodule

`default_nettype wire

/* rtl/core/modular_inverse_ext_euclid.sv */
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid
// Modular inverse of value modulo modulus by the extended Euclidean algorithm.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the cycle in which the result is shown, and a new item may already be
// taken in that cycle. The result appears on result_o for exactly one cycle
// with done_o high, and the receiver must take it then, as it cannot stall.
// Each Euclid step runs one pass of the shared bit-serial divider, which
// yields the remainder and the quotient times the current coefficient
// together; a final pass of the same divider reduces the coefficient modulo
// the modulus. A zero modulus skips the final pass and returns inverse 0
// with the gcd equal to value and invertible low.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_inverse_ext_euclid
  import miv_pkg::*;
#(
  parameter int unsigned OPERAND_BITS = 63
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire miv_in_t  item_i,
  output logic          done_o,
  output miv_out_t      result_o
);

  localparam int unsigned W  = OPERAND_BITS;
  // coefficients stay within +-2^W, one sign bit on top covers them
  localparam int unsigned CW = W + 1;

  miv_state_e state_q, state_d;

  // euclid pair and bezout coefficients of value
  logic [W-1:0]  num_q, num_d;
  logic [W-1:0]  den_q, den_d;
  logic [W-1:0]  mod_q, mod_d;
  logic [CW-1:0] co_q, co_d;
  logic [CW-1:0] cn_q, cn_d;

  logic     done_q, done_d;
  miv_out_t res_q, res_d;

  // shared divider hookup
  logic          div_start;
  logic [W-1:0]  div_dividend;
  logic [W-1:0]  div_divisor;
  logic [CW-1:0] div_mult;
  logic          div_done;
  logic [W-1:0]  div_rem;
  logic [CW-1:0] div_prod;

  // magnitude of the final coefficient for the modulo reduction
  logic [CW-1:0] co_neg;
  logic          co_sign;
  logic [W-1:0]  co_mag;
  logic [W-1:0]  lifted;

  assign co_neg  = -co_q;
  assign co_sign = co_q[CW-1];
  assign co_mag  = co_sign ? co_neg[W-1:0] : co_q[W-1:0];
  // negative coefficient with nonzero remainder gets lifted by the modulus
  assign lifted  = (co_sign && div_rem != '0) ? (mod_q - div_rem) : div_rem;

  miv_divider #(
    .W  (W),
    .CW (CW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .mult_i     (div_mult),
    .done_o     (div_done),
    .rem_o      (div_rem),
    .prod_o     (div_prod)
  );

  always_comb begin
    state_d      = state_q;
    num_d        = num_q;
    den_d        = den_q;
    mod_d        = mod_q;
    co_d         = co_q;
    cn_d         = cn_q;
    done_d       = 1'b0;
    res_d        = res_q;
    div_start    = 1'b0;
    div_dividend = num_q;
    div_divisor  = den_q;
    div_mult     = cn_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          // operands are masked to the configured width
          num_d   = item_i.modulus[W-1:0];
          mod_d   = item_i.modulus[W-1:0];
          den_d   = item_i.value[W-1:0];
          co_d    = '0;
          cn_d    = CW'(1);
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (den_q == '0) begin
          if (mod_q == '0) begin
            // zero modulus: no reduction, gcd is value
            res_d.inverse        = '0;
            res_d.common_divisor = FIELD_W'(num_q);
            res_d.invertible     = 1'b0;
            done_d               = 1'b1;
            state_d              = ST_IDLE;
          end else begin
            // final pass: coefficient magnitude modulo the modulus
            div_start    = 1'b1;
            div_dividend = co_mag;
            div_divisor  = mod_q;
            state_d      = ST_REDUCE;
          end
        end else begin
          // one euclid step: num / den with quotient times cn on the side
          div_start = 1'b1;
          state_d   = ST_STEP;
        end
      end
      ST_STEP: begin
        if (div_done) begin
          num_d   = den_q;
          den_d   = div_rem;
          co_d    = cn_q;
          cn_d    = co_q - div_prod;
          state_d = ST_CHECK;
        end
      end
      ST_REDUCE: begin
        if (div_done) begin
          res_d.inverse        = FIELD_W'(lifted);
          res_d.common_divisor = FIELD_W'(num_q);
          res_d.invertible     = (num_q == W'(1));
          done_d               = 1'b1;
          state_d              = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    mod_q <= mod_d;
    co_q  <= co_d;
    cn_q  <= cn_d;
    res_q <= res_d;
  end

  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

  // an invertible result always carries gcd one
  a_inv_gcd_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && res_q.invertible |-> res_q.common_divisor == FIELD_W'(1))
    else $error("invertible flagged with gcd other than one");

  // a reduced inverse lies below a nonzero modulus
  a_inv_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && mod_q != '0 |-> res_q.inverse < FIELD_W'(mod_q))
    else $error("inverse not reduced below modulus");

  // an accepted item keeps the block busy on the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("item accepted but block not busy");

  // the shared divider is only started from the check state
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> state_q == ST_CHECK && (den_q != '0 || mod_q != '0))
    else $error("divider started outside the check state");

endmodule

`default_nettype wire
